/* sv/fcl_pkg.sv */
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared types and constants of the fully connected layer core.
// ----------------------------------------------------------------------------
package fcl_pkg;

  // Store sizes
  localparam int MAX_INPUTS  = 1024;
  localparam int MAX_OUTPUTS = 1024;
  localparam int ACT_AW      = $clog2(MAX_INPUTS);
  localparam int ROW_AW      = $clog2(MAX_OUTPUTS);

  // Field widths
  localparam int CFG_W  = 11;   // length registers
  localparam int DATA_W = 16;   // Q8.8 activation / weight
  localparam int BIAS_W = 32;   // Q16.16 bias
  localparam int PROD_W = 32;   // Q16.16 product
  localparam int ACC_W  = 48;   // Q32.16 accumulator
  localparam int RES_W  = 32;   // Q16.16 result
  localparam int IDX_W  = 10;   // output index field

  // Operation codes (in_tuser)
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  // Configuration register indices
  localparam logic CFG_IN_LEN  = 1'b0;
  localparam logic CFG_OUT_LEN = 1'b1;

  // Control carried alongside a weight through the MAC pipeline
  typedef struct packed {
    logic              vld;       // stage holds a weight
    logic              row_end;   // last weight of its row
    logic [ROW_AW-1:0] row;       // row index
    logic              smp_end;   // last row of the sample
  } fcl_tag_t;

  // Finished neuron result
  typedef struct packed {
    logic             vld;
    logic [RES_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             last;
  } fcl_res_t;

endpackage

/* sv/fcl_ram.sv */
// ----------------------------------------------------------------------------
// fcl_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fcl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/fcl_mac.sv */
// ----------------------------------------------------------------------------
// fcl_mac
// Multiply-accumulate pipeline: product, 48-bit accumulation, bias add and
// saturation to Q16.16.
// ----------------------------------------------------------------------------
module fcl_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,       // pipeline advance
  input  logic                        clr,      // register write clears the sum
  input  fcl_pkg::fcl_tag_t           tag,      // accepted weight control
  input  logic [fcl_pkg::DATA_W-1:0]  weight,
  input  logic [fcl_pkg::BIAS_W-1:0]  bias,
  input  logic [fcl_pkg::DATA_W-1:0]  act,      // RAM read data, aligned with stage 1
  output fcl_pkg::fcl_res_t           res
);

  fcl_pkg::fcl_tag_t                  s1_tag_r;
  logic signed [fcl_pkg::DATA_W-1:0]  s1_w_r;
  logic        [fcl_pkg::BIAS_W-1:0]  s1_bias_r;

  fcl_pkg::fcl_tag_t                  s2_tag_r;
  logic signed [fcl_pkg::PROD_W-1:0]  s2_prod_r;
  logic        [fcl_pkg::BIAS_W-1:0]  s2_bias_r;

  logic signed [fcl_pkg::ACC_W-1:0]   acc_r;
  logic signed [fcl_pkg::ACC_W-1:0]   acc_nxt;

  logic                               s3_vld_r;
  logic signed [fcl_pkg::ACC_W-1:0]   s3_sum_r;
  logic signed [fcl_pkg::BIAS_W-1:0]  s3_bias_r;
  logic        [fcl_pkg::ROW_AW-1:0]  s3_row_r;
  logic                               s3_last_r;

  logic signed [fcl_pkg::ACC_W-1:0]   tot;
  logic                               in_range;

  // Stage 1: weight waits for the activation read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
    end else if (en) begin
      s1_tag_r <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w_r    <= weight;
      s1_bias_r <= bias;
    end
  end

  // Stage 2: exact Q8.8 x Q8.8 product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r <= '0;
    end else if (en) begin
      s2_tag_r <= s1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod_r <= $signed(act) * s1_w_r;
      s2_bias_r <= s1_bias_r;
    end
  end

  // Stage 3: accumulate; a row end hands its sum on and clears the sum
  assign acc_nxt = acc_r + fcl_pkg::ACC_W'(s2_prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      s3_vld_r <= 1'b0;
    end else if (clr) begin
      acc_r    <= '0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_tag_r.vld && s2_tag_r.row_end;
      if (s2_tag_r.vld) begin
        acc_r <= s2_tag_r.row_end ? '0 : acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum_r  <= acc_nxt;
      s3_bias_r <= s2_bias_r;
      s3_row_r  <= s2_tag_r.row;
      s3_last_r <= s2_tag_r.smp_end;
    end
  end

  // Bias add and clamp to signed 32 bits
  assign tot      = s3_sum_r + fcl_pkg::ACC_W'(s3_bias_r);
  assign in_range = (&tot[fcl_pkg::ACC_W-1:fcl_pkg::RES_W-1])
                 || !(|tot[fcl_pkg::ACC_W-1:fcl_pkg::RES_W-1]);

  always_comb begin
    res.vld   = s3_vld_r;
    res.index = fcl_pkg::IDX_W'(s3_row_r);
    res.last  = s3_last_r;
    if (in_range) begin
      res.value = tot[fcl_pkg::RES_W-1:0];
    end else if (tot[fcl_pkg::ACC_W-1]) begin
      res.value = {1'b1, {(fcl_pkg::RES_W-1){1'b0}}};
    end else begin
      res.value = {1'b0, {(fcl_pkg::RES_W-1){1'b1}}};
    end
  end

  // A finished row always leaves a cleared sum behind it
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> acc_r == '0)
    else $error("accumulator not cleared after row end");

endmodule

/* sv/fully_connected_layer_core.sv */
// ----------------------------------------------------------------------------
// fully_connected_layer_core
// Fully connected layer, one sample at a time, Q8.8 inputs, Q16.16 results.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle unless the input is stalled, loads and
// weights alike, with no gaps between rows or samples. Activations live in a
// single RAM: a load writes it at the load pointer, a weight reads it at the
// weight pointer, so one write and one read port carry the full rate. A
// result is presented once the last weight of its row has passed the MAC
// pipeline (activation read at the transfer edge, then multiply, accumulate,
// and bias add with clamp into the output register). A two-entry output
// slice keeps the input side flowing while a result waits to be taken;
// input stalls only while both entries are occupied. The activation store
// needs no clearing after reset; entries not yet loaded read as whatever
// the RAM holds. Writing either length register restarts the load, weight
// and row pointers and clears the running sum.
// ----------------------------------------------------------------------------
module fully_connected_layer_core (
  input  logic        clk,
  input  logic        rst_n,

  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] data, [47:16] row_bias
  input  logic        in_tuser,   // [0] operation

  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] result_value, [41:32] output_index, zero pad
  output logic        out_tlast,  // last_of_sample

  // Configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wdata
);

  localparam int PAD_W = 48 - fcl_pkg::RES_W - fcl_pkg::IDX_W;

  logic [fcl_pkg::CFG_W-1:0]  in_len_r;
  logic [fcl_pkg::CFG_W-1:0]  out_len_r;
  logic [fcl_pkg::CFG_W-1:0]  n_in;
  logic [fcl_pkg::CFG_W-1:0]  n_out;

  logic [fcl_pkg::ACT_AW-1:0] load_pos_r;
  logic [fcl_pkg::ACT_AW-1:0] wt_pos_r;
  logic [fcl_pkg::ROW_AW-1:0] row_pos_r;

  logic                       accept;
  logic                       is_load;
  logic                       is_weight;
  logic                       load_end;
  logic                       row_end;
  logic                       smp_end;

  logic [fcl_pkg::DATA_W-1:0] act;
  fcl_pkg::fcl_tag_t          tag;
  fcl_pkg::fcl_res_t          res;

  logic                       out_v_r;
  fcl_pkg::fcl_res_t          out_r;
  logic                       skid_v_r;
  fcl_pkg::fcl_res_t          skid_r;

  // Effective lengths: zero acts as one, oversize as the maximum
  always_comb begin
    if (in_len_r == '0) begin
      n_in = fcl_pkg::CFG_W'(1);
    end else if (in_len_r > fcl_pkg::CFG_W'(fcl_pkg::MAX_INPUTS)) begin
      n_in = fcl_pkg::CFG_W'(fcl_pkg::MAX_INPUTS);
    end else begin
      n_in = in_len_r;
    end
    if (out_len_r == '0) begin
      n_out = fcl_pkg::CFG_W'(1);
    end else if (out_len_r > fcl_pkg::CFG_W'(fcl_pkg::MAX_OUTPUTS)) begin
      n_out = fcl_pkg::CFG_W'(fcl_pkg::MAX_OUTPUTS);
    end else begin
      n_out = out_len_r;
    end
  end

  // Input transfer and pointer wrap points
  assign in_tready = !skid_v_r;
  assign accept    = in_tvalid && in_tready;
  assign is_load   = accept && (in_tuser == fcl_pkg::OP_LOAD);
  assign is_weight = accept && (in_tuser == fcl_pkg::OP_WEIGHT);
  assign load_end  = (fcl_pkg::CFG_W'(load_pos_r) + fcl_pkg::CFG_W'(1)) == n_in;
  assign row_end   = (fcl_pkg::CFG_W'(wt_pos_r) + fcl_pkg::CFG_W'(1)) == n_in;
  assign smp_end   = (fcl_pkg::CFG_W'(row_pos_r) + fcl_pkg::CFG_W'(1)) == n_out;

  // Length registers and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_len_r   <= fcl_pkg::CFG_W'(1);
      out_len_r  <= fcl_pkg::CFG_W'(1);
      load_pos_r <= '0;
      wt_pos_r   <= '0;
      row_pos_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fcl_pkg::CFG_IN_LEN:  in_len_r  <= cfg_wdata;
        fcl_pkg::CFG_OUT_LEN: out_len_r <= cfg_wdata;
        default: ;
      endcase
      load_pos_r <= '0;
      wt_pos_r   <= '0;
      row_pos_r  <= '0;
    end else begin
      if (is_load) begin
        load_pos_r <= load_end ? '0 : load_pos_r + 1'b1;
      end
      if (is_weight) begin
        wt_pos_r <= row_end ? '0 : wt_pos_r + 1'b1;
        if (row_end) begin
          row_pos_r <= smp_end ? '0 : row_pos_r + 1'b1;
        end
      end
    end
  end

  // Activation store
  fcl_ram #(
    .WIDTH (fcl_pkg::DATA_W),
    .DEPTH (fcl_pkg::MAX_INPUTS)
  ) u_act_ram (
    .clk   (clk),
    .we    (is_load),
    .waddr (load_pos_r),
    .wdata (in_tdata[fcl_pkg::DATA_W-1:0]),
    .re    (is_weight),
    .raddr (wt_pos_r),
    .rdata (act)
  );

  // MAC pipeline
  always_comb begin
    tag.vld     = is_weight;
    tag.row_end = row_end;
    tag.row     = row_pos_r;
    tag.smp_end = smp_end;
  end

  fcl_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (in_tready),
    .clr    (cfg_we),
    .tag    (tag),
    .weight (in_tdata[fcl_pkg::DATA_W-1:0]),
    .bias   (in_tdata[fcl_pkg::DATA_W +: fcl_pkg::BIAS_W]),
    .act    (act),
    .res    (res)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= res.vld;
      end
    end else if (res.vld && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (!skid_v_r) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_r.index, out_r.value};
  assign out_tlast  = out_r.last;

  // Skid entry only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid with empty output register");

  // Pointers stay inside the configured lengths
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fcl_pkg::CFG_W'(load_pos_r) < n_in) && (fcl_pkg::CFG_W'(wt_pos_r) < n_in))
    else $error("activation pointer beyond input length");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fcl_pkg::CFG_W'(row_pos_r) < n_out)
    else $error("row pointer beyond output length");

endmodule
